// ----- rtl/core/stt_pkg.sv -----
`timescale 1ns / 1ps
// stt_pkg: shared types and codes of the sorted timeout table
// operation kinds, status codes, compare modes and the result record
// no dependencies
package stt_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;

    // entry record without the timeout: addr 8, period 16, flag 1, handle 16
    localparam int ENTRY_FIXED_W = 41;

    localparam logic [2:0] KIND_PUT      = 3'd0;
    localparam logic [2:0] KIND_UPDATE   = 3'd1;
    localparam logic [2:0] KIND_DELETE   = 3'd2;
    localparam logic [2:0] KIND_LOOKUP   = 3'd3;
    localparam logic [2:0] KIND_FIND_MSG = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef enum logic [1:0] {
        CMP_ADDR    = 2'd0,
        CMP_FLAG    = 2'd1,
        CMP_TIME_GE = 2'd2
    } t_cmp_mode;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  position;
        logic [7:0]  entry_addr;
        logic [31:0] entry_timeout;
        logic [15:0] entry_period;
        logic        entry_has_message;
        logic [15:0] entry_message_handle;
        logic [8:0]  entry_count;
    } t_result;

endpackage

// ----- rtl/core/stt_cmp.sv -----
`timescale 1ns / 1ps
// stt_cmp: shared compare unit of the table sequencer
// address match, message flag test or timeout greater-or-equal; uses stt_pkg
module stt_cmp #(
    parameter int TIME_BITS = stt_pkg::TIME_BITS_DEF
) (
    input  stt_pkg::t_cmp_mode    i_mode,
    input  logic [7:0]            i_addr,
    input  logic [7:0]            i_key_addr,
    input  logic [TIME_BITS-1:0]  i_timeout,
    input  logic [TIME_BITS-1:0]  i_key_timeout,
    input  logic                  i_flag,
    output logic                  o_hit
);

    always_comb begin
        case (i_mode)
            stt_pkg::CMP_ADDR:    o_hit = (i_addr == i_key_addr);
            stt_pkg::CMP_FLAG:    o_hit = i_flag;
            stt_pkg::CMP_TIME_GE: o_hit = (i_timeout >= i_key_timeout);
            default:              o_hit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/core/stt_store.sv -----
`timescale 1ns / 1ps
// stt_store: entry memory of the sorted timeout table
// one write port and one read port with registered read data; no dependencies
module stt_store #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 73,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/stt_seq.sv -----
`timescale 1ns / 1ps
// stt_seq: sequencer of the sorted timeout table
// walks the entry memory one slot per step through the shared compare unit
// depends on stt_pkg and stt_cmp
module stt_seq #(
    parameter int CAPACITY  = stt_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = stt_pkg::TIME_BITS_DEF,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int ENTRY_W  = TIME_BITS + stt_pkg::ENTRY_FIXED_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0]           i_kind,
    input  logic [7:0]           i_dev_addr,
    input  logic [31:0]          i_new_timeout,
    input  logic [15:0]          i_period,
    input  logic [31:0]          i_now_time,
    input  logic                 i_has_message,
    input  logic [15:0]          i_message_handle,
    output logic                 o_idle,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output stt_pkg::t_result     o_result,
    output logic                 o_wr_en,
    output logic [IDX_W-1:0]     o_wr_idx,
    output logic [ENTRY_W-1:0]   o_wr_data,
    output logic [IDX_W-1:0]     o_rd_idx,
    input  logic [ENTRY_W-1:0]   i_rd_data
);

    typedef struct packed {
        logic [7:0]           addr;
        logic [TIME_BITS-1:0] timeout;
        logic [15:0]          period;
        logic                 flag;
        logic [15:0]          handle;
    } t_entry;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_FIND_RD  = 10'b00_0000_0010,
        S_FIND_CHK = 10'b00_0000_0100,
        S_RM_RD    = 10'b00_0000_1000,
        S_RM_WR    = 10'b00_0001_0000,
        S_INS_RD   = 10'b00_0010_0000,
        S_INS_CHK  = 10'b00_0100_0000,
        S_SH_RD    = 10'b00_1000_0000,
        S_SH_WR    = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_state               r_state, n_state;
    logic [2:0]           r_kind, n_kind;
    logic [7:0]           r_key, n_key;
    logic [TIME_BITS-1:0] r_tmo, n_tmo;
    logic [TIME_BITS-1:0] r_ref_tmo, n_ref_tmo;
    logic [15:0]          r_period, n_period;
    logic                 r_hasm, n_hasm;
    logic [15:0]          r_hnd, n_hnd;
    t_entry               r_slot, n_slot;
    logic [CNT_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [1:0]           r_status, n_status;
    logic                 r_do_insert, n_do_insert;

    t_entry               rd_entry;
    t_entry               new_entry;
    t_entry               upd_entry;
    t_entry               ref_entry;
    logic [CNT_W-1:0]     ptr_m1;
    logic [CNT_W-1:0]     ptr_p1;
    stt_pkg::t_cmp_mode   cmp_mode;
    logic                 cmp_hit;

    assign rd_entry = t_entry'(i_rd_data);
    assign ptr_m1   = r_ptr - CNT_ONE;
    assign ptr_p1   = r_ptr + CNT_ONE;

    always_comb begin
        new_entry.addr    = r_key;
        new_entry.timeout = r_tmo;
        new_entry.period  = r_period;
        new_entry.flag    = r_hasm;
        new_entry.handle  = r_hasm ? r_hnd : 16'd0;

        upd_entry         = rd_entry;
        upd_entry.timeout = r_tmo;

        ref_entry         = rd_entry;
        ref_entry.period  = r_period;
        ref_entry.timeout = r_ref_tmo;
    end

    always_comb begin
        if (r_state == S_INS_CHK) begin
            cmp_mode = stt_pkg::CMP_TIME_GE;
        end else if (r_kind == stt_pkg::KIND_FIND_MSG) begin
            cmp_mode = stt_pkg::CMP_FLAG;
        end else begin
            cmp_mode = stt_pkg::CMP_ADDR;
        end
    end

    stt_cmp #(
        .TIME_BITS(TIME_BITS)
    ) u_cmp (
        .i_mode        (cmp_mode),
        .i_addr        (rd_entry.addr),
        .i_key_addr    (r_key),
        .i_timeout     (rd_entry.timeout),
        .i_key_timeout (r_slot.timeout),
        .i_flag        (rd_entry.flag),
        .o_hit         (cmp_hit)
    );

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_key       = r_key;
        n_tmo       = r_tmo;
        n_ref_tmo   = r_ref_tmo;
        n_period    = r_period;
        n_hasm      = r_hasm;
        n_hnd       = r_hnd;
        n_slot      = r_slot;
        n_ptr       = r_ptr;
        n_pos       = r_pos;
        n_count     = r_count;
        n_status    = r_status;
        n_do_insert = r_do_insert;
        o_wr_en     = 1'b0;
        o_wr_idx    = r_ptr[IDX_W-1:0];
        o_wr_data   = ENTRY_W'(r_slot);
        o_rd_idx    = r_ptr[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind    = i_kind;
                    n_key     = i_dev_addr;
                    n_tmo     = TIME_BITS'(i_new_timeout);
                    n_ref_tmo = TIME_BITS'(i_now_time) + TIME_BITS'(i_period);
                    n_period  = i_period;
                    n_hasm    = i_has_message;
                    n_hnd     = i_message_handle;
                    n_ptr     = '0;
                    case (i_kind)
                        stt_pkg::KIND_PUT: begin
                            // put with a message skips the address search
                            if (i_has_message) begin
                                n_ptr = r_count;
                            end
                            n_state = S_FIND_RD;
                        end
                        stt_pkg::KIND_UPDATE,
                        stt_pkg::KIND_DELETE,
                        stt_pkg::KIND_LOOKUP,
                        stt_pkg::KIND_FIND_MSG: begin
                            n_state = S_FIND_RD;
                        end
                        default: begin
                            n_status = stt_pkg::ST_NONE;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                if (r_ptr == r_count) begin
                    case (r_kind)
                        stt_pkg::KIND_PUT: begin
                            if (r_count >= CAP_CNT) begin
                                n_status = stt_pkg::ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_slot  = new_entry;
                                n_ptr   = '0;
                                n_state = S_INS_RD;
                            end
                        end
                        stt_pkg::KIND_FIND_MSG: begin
                            n_status = stt_pkg::ST_NONE;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_status = stt_pkg::ST_MISSING;
                            n_state  = S_DONE;
                        end
                    endcase
                end else begin
                    n_state = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (cmp_hit) begin
                    n_pos    = r_ptr;
                    n_status = stt_pkg::ST_OK;
                    n_ptr    = ptr_p1;
                    case (r_kind)
                        stt_pkg::KIND_DELETE: begin
                            n_slot      = rd_entry;
                            n_do_insert = 1'b0;
                            n_state     = S_RM_RD;
                        end
                        stt_pkg::KIND_UPDATE: begin
                            n_slot      = upd_entry;
                            n_do_insert = 1'b1;
                            n_state     = S_RM_RD;
                        end
                        stt_pkg::KIND_PUT: begin
                            n_slot      = ref_entry;
                            n_do_insert = 1'b1;
                            n_state     = S_RM_RD;
                        end
                        default: begin
                            n_slot  = rd_entry;
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    n_ptr   = ptr_p1;
                    n_state = S_FIND_RD;
                end
            end
            S_RM_RD: begin
                if (r_ptr == r_count) begin
                    n_count = r_count - CNT_ONE;
                    if (r_do_insert) begin
                        n_ptr   = '0;
                        n_state = S_INS_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_RM_WR;
                end
            end
            S_RM_WR: begin
                o_wr_en   = 1'b1;
                o_wr_idx  = ptr_m1[IDX_W-1:0];
                o_wr_data = i_rd_data;
                n_ptr     = ptr_p1;
                n_state   = S_RM_RD;
            end
            S_INS_RD: begin
                if (r_ptr == r_count) begin
                    n_pos   = r_count;
                    n_ptr   = r_count;
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (cmp_hit) begin
                    n_pos   = r_ptr;
                    n_ptr   = r_count;
                    n_state = S_SH_RD;
                end else begin
                    n_ptr   = ptr_p1;
                    n_state = S_INS_RD;
                end
            end
            S_SH_RD: begin
                o_rd_idx = ptr_m1[IDX_W-1:0];
                if (r_ptr == r_pos) begin
                    o_wr_en   = 1'b1;
                    o_wr_idx  = r_pos[IDX_W-1:0];
                    o_wr_data = ENTRY_W'(r_slot);
                    n_count   = r_count + CNT_ONE;
                    n_status  = stt_pkg::ST_OK;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_wr_en   = 1'b1;
                o_wr_idx  = r_ptr[IDX_W-1:0];
                o_wr_data = i_rd_data;
                n_ptr     = ptr_m1;
                n_state   = S_SH_RD;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= stt_pkg::ST_OK;
            r_do_insert <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_status    <= n_status;
            r_do_insert <= n_do_insert;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_tmo     <= n_tmo;
        r_ref_tmo <= n_ref_tmo;
        r_period  <= n_period;
        r_hasm    <= n_hasm;
        r_hnd     <= n_hnd;
        r_slot    <= n_slot;
        r_ptr     <= n_ptr;
        r_pos     <= n_pos;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_result.status      = r_status;
        o_result.entry_count = 9'(r_count);
        if (r_status == stt_pkg::ST_OK) begin
            o_result.position             = 8'(r_pos);
            o_result.entry_addr           = r_slot.addr;
            o_result.entry_timeout        = 32'(r_slot.timeout);
            o_result.entry_period         = r_slot.period;
            o_result.entry_has_message    = r_slot.flag;
            o_result.entry_message_handle = r_slot.handle;
        end else begin
            o_result.position             = 8'd0;
            o_result.entry_addr           = 8'd0;
            o_result.entry_timeout        = 32'd0;
            o_result.entry_period         = 16'd0;
            o_result.entry_has_message    = 1'b0;
            o_result.entry_message_handle = 16'd0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (CNT_W'(o_wr_idx) <= r_count))
        else $error("write beyond the occupied part of the table");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_status == stt_pkg::ST_FULL) |-> (r_count == CAP_CNT))
        else $error("full status with room left");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CNT_ONE || r_count == $past(r_count) - CNT_ONE))
        else $error("entry count jumped");

    a_idle_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_idle || o_res_valid) |-> !o_wr_en)
        else $error("memory write outside an operation");

endmodule

// ----- rtl/core/sorted_timeout_table.sv -----
`timescale 1ns / 1ps
// sorted_timeout_table: table of device timeouts kept in ascending order
// input channel of operations, output channel of one result per transaction
// depends on stt_pkg, stt_seq, stt_store
//
// Usage: an operation (put, update, delete, lookup, find first with message)
// is a transaction on i_in_valid / o_in_ready with its fields on i_* ports.
// Each one yields exactly one result transaction on o_out_valid / i_out_ready.
// The block holds one operation at a time; o_in_ready is high only while the
// sequencer is idle. Entries live in a single-port-read memory with registered
// read data, and the sequencer visits one slot at a time through one
// shared compare unit. A lookup or find stops at the hit, a delete searches
// and then closes the gap, and an update or put refresh also re-inserts the
// entry in order; a put that inserts searches for the address and then the
// insertion point, except with a message, which skips the address search.
// The result sits in an output register: the next transaction
// is accepted while it waits, and a stalled receiver holds the finished
// result in the sequencer until the register frees. Reset empties the table
// at once, with no clearing pass; memory contents need no reset.
module sorted_timeout_table #(
    parameter int CAPACITY  = stt_pkg::CAPACITY_DEF,
    parameter int TIME_BITS = stt_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_dev_addr,
    input  logic [31:0] i_new_timeout,
    input  logic [15:0] i_period,
    input  logic [31:0] i_now_time,
    input  logic        i_has_message,
    input  logic [15:0] i_message_handle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_position,
    output logic [7:0]  o_entry_addr,
    output logic [31:0] o_entry_timeout,
    output logic [15:0] o_entry_period,
    output logic        o_entry_has_message,
    output logic [15:0] o_entry_message_handle,
    output logic [8:0]  o_entry_count
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int ENTRY_W = TIME_BITS + stt_pkg::ENTRY_FIXED_W;

    logic               seq_idle;
    logic               res_valid;
    logic               res_ready;
    stt_pkg::t_result   seq_result;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ENTRY_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_idx;
    logic [ENTRY_W-1:0] rd_data;

    logic               r_out_valid;
    stt_pkg::t_result   r_out;

    assign o_in_ready = seq_idle;
    assign res_ready  = !r_out_valid || i_out_ready;

    stt_seq #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_in_valid && seq_idle),
        .i_kind           (i_kind),
        .i_dev_addr       (i_dev_addr),
        .i_new_timeout    (i_new_timeout),
        .i_period         (i_period),
        .i_now_time       (i_now_time),
        .i_has_message    (i_has_message),
        .i_message_handle (i_message_handle),
        .o_idle           (seq_idle),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_result         (seq_result),
        .o_wr_en          (wr_en),
        .o_wr_idx         (wr_idx),
        .o_wr_data        (wr_data),
        .o_rd_idx         (rd_idx),
        .i_rd_data        (rd_data)
    );

    stt_store #(
        .DEPTH  (CAPACITY),
        .DATA_W (ENTRY_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_status               = r_out.status;
    assign o_position             = r_out.position;
    assign o_entry_addr           = r_out.entry_addr;
    assign o_entry_timeout        = r_out.entry_timeout;
    assign o_entry_period         = r_out.entry_period;
    assign o_entry_has_message    = r_out.entry_has_message;
    assign o_entry_message_handle = r_out.entry_message_handle;
    assign o_entry_count          = r_out.entry_count;

endmodule
